@@ rtl/core/mgmt_pkg.sv @@
// Shared constants and types for the multicast group member table.
`timescale 1ns / 1ps
package mgmt_pkg;
    localparam int GROUP_SLOTS  = 128;
    localparam int MEMBER_SLOTS = 32;
    localparam int GS_W         = $clog2(GROUP_SLOTS);
    localparam int MS_W         = $clog2(MEMBER_SLOTS);
    localparam int MEM_DEPTH    = GROUP_SLOTS * MEMBER_SLOTS;
    localparam int MA_W         = $clog2(MEM_DEPTH);
    localparam int MAC_W        = 48;

    localparam logic [MAC_W-1:0] UPNP_GROUP       = 48'h01005E7FFFFA;
    localparam logic [23:0]      SOLICITED_PREFIX = 24'h3333FF;

    typedef enum logic [3:0] {
        ST_FILTERED   = 4'd0,
        ST_CREATED    = 4'd1,
        ST_ADDED      = 4'd2,
        ST_ALREADY    = 4'd3,
        ST_TABLE_FULL = 4'd4,
        ST_GROUP_FULL = 4'd5,
        ST_REMOVED    = 4'd6,
        ST_FREED      = 4'd7,
        ST_NO_GROUP   = 4'd8,
        ST_NO_MEMBER  = 4'd9
    } status_t;

    typedef enum logic {
        OP_JOIN  = 1'b0,
        OP_LEAVE = 1'b1
    } op_t;
endpackage

@@ rtl/core/mgmt_ram.sv @@
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module mgmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/core/multicast_group_member_table_core.sv @@
// Top level: request sequencer around the group and member memories.
//   channel | dir | tdata                                  | tuser
//   s_*     | in  | [47:0] group_mac, [95:48] member_mac   | [0] op
//   m_*     | out | [3:0] status, [10:4] group_slot        | -
// One request at a time: the group scan reads one group address per cycle,
// then the member scan reads one member address per cycle.
// Reset clears the group valid flops; member valid rows are rewritten when a
// group is created, so no clearing pass is needed.
// A new request is taken while the previous result waits on the output.
`timescale 1ns / 1ps
module multicast_group_member_table_core
    import mgmt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // group_mac [47:0], member_mac [95:48]
    input  logic [0:0]   s_tuser,   // op [0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata    // status [3:0], group_slot [10:4]
);
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_GSCAN = 5'b00010,
        S_VRD   = 5'b00100,
        S_MSCAN = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    op_t op_reg, op_next;
    logic [MAC_W-1:0] g_reg, g_next, m_reg, m_next;
    logic [GROUP_SLOTS-1:0] gvalid_reg, gvalid_next;
    logic [GS_W:0] gidx_reg, gidx_next;
    logic gcv_reg, gcv_next;
    logic [GS_W-1:0] gcidx_reg, gcidx_next;
    logic gfree_ok_reg, gfree_ok_next;
    logic [GS_W-1:0] gfree_reg, gfree_next;
    logic [GS_W-1:0] gs_reg, gs_next;
    logic [MS_W:0] midx_reg, midx_next;
    logic mcv_reg, mcv_next;
    logic [MS_W-1:0] mcidx_reg, mcidx_next;
    logic mfree_ok_reg, mfree_ok_next;
    logic [MS_W-1:0] mfree_reg, mfree_next;
    status_t status_reg, status_next;
    logic [GS_W-1:0] slot_reg, slot_next;
    logic out_valid_reg, out_valid_next;
    logic [15:0] out_data_reg, out_data_next;

    logic gram_we;
    logic [GS_W-1:0] gram_waddr;
    logic [MAC_W-1:0] gram_rdata;
    logic mram_we;
    logic [MA_W-1:0] mram_waddr, mram_raddr;
    logic [MAC_W-1:0] mram_rdata;
    logic vram_we;
    logic [GS_W-1:0] vram_waddr;
    logic [MEMBER_SLOTS-1:0] vram_wdata, vram_rdata;

    logic [MAC_W-1:0] in_g;
    logic filtered;
    logic gmatch, mmatch;
    logic [MS_W-1:0] jsel;
    logic [MEMBER_SLOTS-1:0] jbit, row_left;

    assign in_g = s_tdata[47:0];
    assign filtered = (in_g == UPNP_GROUP) || (in_g[47:24] == SOLICITED_PREFIX);
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign gmatch = gcv_reg && gvalid_reg[gcidx_reg] && (gram_rdata == g_reg);
    assign mmatch = mcv_reg && vram_rdata[mcidx_reg] && (mram_rdata == m_reg);
    assign mram_raddr = MA_W'(gs_reg) * MA_W'(MEMBER_SLOTS) + MA_W'(midx_reg);
    assign row_left = vram_rdata & ~jbit;

    mgmt_ram #(.WIDTH(MAC_W), .DEPTH(GROUP_SLOTS)) u_group_ram (
        .clk(clk), .we(gram_we), .waddr(gram_waddr), .wdata(g_reg),
        .raddr(gidx_reg[GS_W-1:0]), .rdata(gram_rdata)
    );
    mgmt_ram #(.WIDTH(MAC_W), .DEPTH(MEM_DEPTH)) u_member_ram (
        .clk(clk), .we(mram_we), .waddr(mram_waddr), .wdata(m_reg),
        .raddr(mram_raddr), .rdata(mram_rdata)
    );
    mgmt_ram #(.WIDTH(MEMBER_SLOTS), .DEPTH(GROUP_SLOTS)) u_valid_ram (
        .clk(clk), .we(vram_we), .waddr(vram_waddr), .wdata(vram_wdata),
        .raddr(gs_reg), .rdata(vram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        g_next         = g_reg;
        m_next         = m_reg;
        gvalid_next    = gvalid_reg;
        gidx_next      = gidx_reg;
        gcv_next       = 1'b0;
        gcidx_next     = gidx_reg[GS_W-1:0];
        gfree_ok_next  = gfree_ok_reg;
        gfree_next     = gfree_reg;
        gs_next        = gs_reg;
        midx_next      = midx_reg;
        mcv_next       = 1'b0;
        mcidx_next     = midx_reg[MS_W-1:0];
        mfree_ok_next  = mfree_ok_reg;
        mfree_next     = mfree_reg;
        status_next    = status_reg;
        slot_next      = slot_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        gram_we        = 1'b0;
        gram_waddr     = gfree_reg;
        mram_we        = 1'b0;
        mram_waddr     = MA_W'(gfree_reg) * MA_W'(MEMBER_SLOTS);
        vram_we        = 1'b0;
        vram_waddr     = gfree_reg;
        vram_wdata     = MEMBER_SLOTS'(1);
        jsel           = mfree_reg;
        if (op_reg == OP_LEAVE)
        begin
            jsel = mcidx_reg;
        end
        jbit = MEMBER_SLOTS'(1) << jsel;

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next       = op_t'(s_tuser[0]);
                    g_next        = in_g;
                    m_next        = s_tdata[95:48];
                    gidx_next     = '0;
                    gfree_ok_next = 1'b0;
                    slot_next     = '0;
                    if (op_t'(s_tuser[0]) == OP_JOIN && filtered)
                    begin
                        status_next = ST_FILTERED;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_GSCAN;
                    end
                end
            end
            S_GSCAN:
            begin
                // Reads are issued ahead of the compare, which uses the registered read data and index.
                if (gidx_reg < (GS_W+1)'(GROUP_SLOTS))
                begin
                    gcv_next  = 1'b1;
                    gidx_next = gidx_reg + 1'b1;
                end
                if (gcv_reg && !gvalid_reg[gcidx_reg] && !gfree_ok_reg)
                begin
                    gfree_ok_next = 1'b1;
                    gfree_next    = gcidx_reg;
                end
                if (gmatch)
                begin
                    gs_next      = gcidx_reg;
                    slot_next    = gcidx_reg;
                    midx_next    = '0;
                    mfree_ok_next = 1'b0;
                    state_next   = S_VRD;
                end
                else if (gcv_reg && gcidx_reg == GS_W'(GROUP_SLOTS - 1))
                begin
                    state_next = S_DONE;
                    if (op_reg == OP_LEAVE)
                    begin
                        status_next = ST_NO_GROUP;
                    end
                    else if (!gfree_ok_next)
                    begin
                        status_next = ST_TABLE_FULL;
                    end
                    else
                    begin
                        status_next = ST_CREATED;
                        slot_next   = gfree_next;
                        gram_we     = 1'b1;
                        gram_waddr  = gfree_next;
                        vram_we     = 1'b1;
                        vram_waddr  = gfree_next;
                        vram_wdata  = MEMBER_SLOTS'(1);
                        mram_we     = 1'b1;
                        mram_waddr  = MA_W'(gfree_next) * MA_W'(MEMBER_SLOTS);
                        gvalid_next[gfree_next] = 1'b1;
                    end
                end
            end
            S_VRD:
            begin
                state_next = S_MSCAN;
            end
            S_MSCAN:
            begin
                if (midx_reg < (MS_W+1)'(MEMBER_SLOTS))
                begin
                    mcv_next  = 1'b1;
                    midx_next = midx_reg + 1'b1;
                end
                if (mcv_reg && !vram_rdata[mcidx_reg] && !mfree_ok_reg)
                begin
                    mfree_ok_next = 1'b1;
                    mfree_next    = mcidx_reg;
                end
                mram_waddr = MA_W'(gs_reg) * MA_W'(MEMBER_SLOTS) + MA_W'(mfree_next);
                vram_waddr = gs_reg;
                if (op_reg == OP_JOIN)
                begin
                    jbit = MEMBER_SLOTS'(1) << mfree_next;
                end
                if (mmatch)
                begin
                    state_next = S_DONE;
                    if (op_reg == OP_JOIN)
                    begin
                        status_next = ST_ALREADY;
                    end
                    else
                    begin
                        vram_we    = 1'b1;
                        vram_wdata = row_left;
                        if (row_left == '0)
                        begin
                            status_next = ST_FREED;
                            gvalid_next[gs_reg] = 1'b0;
                        end
                        else
                        begin
                            status_next = ST_REMOVED;
                        end
                    end
                end
                else if (mcv_reg && mcidx_reg == MS_W'(MEMBER_SLOTS - 1))
                begin
                    state_next = S_DONE;
                    if (op_reg == OP_LEAVE)
                    begin
                        status_next = ST_NO_MEMBER;
                    end
                    else if (!mfree_ok_next)
                    begin
                        status_next = ST_GROUP_FULL;
                    end
                    else
                    begin
                        status_next = ST_ADDED;
                        mram_we     = 1'b1;
                        vram_we     = 1'b1;
                        vram_wdata  = vram_rdata | jbit;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {5'b0, 7'(slot_reg), status_reg};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
            gcv_reg       <= 1'b0;
            mcv_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gvalid_reg    <= gvalid_next;
            out_valid_reg <= out_valid_next;
            gcv_reg       <= gcv_next;
            mcv_reg       <= mcv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        g_reg        <= g_next;
        m_reg        <= m_next;
        gidx_reg     <= gidx_next;
        gcidx_reg    <= gcidx_next;
        gfree_ok_reg <= gfree_ok_next;
        gfree_reg    <= gfree_next;
        gs_reg       <= gs_next;
        midx_reg     <= midx_next;
        mcidx_reg    <= mcidx_next;
        mfree_ok_reg <= mfree_ok_next;
        mfree_reg    <= mfree_next;
        status_reg   <= status_next;
        slot_reg     <= slot_next;
        out_data_reg <= out_data_next;
    end
endmodule
